FILE: design/nscg_pkg.sv
// ----------------------------------------------------------------------------
// Nine-slice cell generator package
// Shared constants, mode codes and controller command/status types.
// ----------------------------------------------------------------------------
package nscg_pkg;

    localparam int DEFAULT_MAX_POINTS = 9;

    localparam logic [1:0] MODE_STRETCH   = 2'd0;
    localparam logic [1:0] MODE_TILE      = 2'd1;
    localparam logic [1:0] MODE_TILE_FULL = 2'd2;

    localparam logic [2:0] REG_FRAME_W  = 3'd0;
    localparam logic [2:0] REG_FRAME_H  = 3'd1;
    localparam logic [2:0] REG_GUIDE_XL = 3'd2;
    localparam logic [2:0] REG_GUIDE_XR = 3'd3;
    localparam logic [2:0] REG_GUIDE_YT = 3'd4;
    localparam logic [2:0] REG_GUIDE_YB = 3'd5;
    localparam logic [2:0] REG_HMODE    = 3'd6;
    localparam logic [2:0] REG_VMODE    = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the input item and start setup
        logic div_start;   // start the texture guide division selected by div_sel
        logic [1:0] div_sel;
        logic pts_step;    // build one point on both axes
        logic emit;        // present the current cell on the output register
        logic advance;     // move to the next cell
    } nscg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic pts_done;
        logic last;        // current cell is the final one
    } nscg_status_t;

endpackage

FILE: design/nscg_divider.sv
// ----------------------------------------------------------------------------
// Nine-slice texture guide divider
// Computes clamp(lo + floor((hi-lo)*g / frame)) one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nscg_divider
    import nscg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] lo,
    input  logic [15:0] hi,
    input  logic [11:0] guide,
    input  logic [11:0] frame,
    output logic        done,
    output logic [15:0] result
);

    // |(hi-lo)*g| fits in 28 bits.
    logic [27:0] num_reg, num_next;
    logic [27:0] quo_reg, quo_next;
    logic [12:0] rem_reg, rem_next;
    logic [11:0] den_reg, den_next;
    logic [15:0] lo_reg, lo_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic [12:0]        trial;
    logic signed [29:0] q_signed;
    logic signed [29:0] sum;
    logic               round_up;

    always_comb
    begin
        diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
        mag  = diff[16] ? 17'(-diff) : 17'(diff);
        trial = {rem_reg[11:0], num_reg[27]};
        round_up = neg_reg && (rem_reg != 13'd0);
        q_signed = neg_reg ? -$signed({2'b00, quo_reg}) - 30'(round_up)
                           : $signed({2'b00, quo_reg});
        sum = $signed({14'd0, lo_reg}) + q_signed;

        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        lo_next   = lo_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            num_next  = 28'(mag * 29'(guide));
            quo_next  = '0;
            rem_next  = '0;
            den_next  = (frame == 12'd0) ? 12'd1 : frame;
            lo_next   = lo;
            neg_next  = diff[16];
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[26:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[26:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[26:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd27)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        lo_reg  <= lo_next;
        neg_reg <= neg_next;
    end

    assign done   = done_reg;
    assign result = (sum < 0) ? 16'd0 : (sum > 30'sd65535) ? 16'hFFFF : sum[15:0];

endmodule

FILE: design/nscg_datapath.sv
// ----------------------------------------------------------------------------
// Nine-slice datapath
// Holds the item, texture guides, point lists and cell counters.
// ----------------------------------------------------------------------------
module nscg_datapath
    import nscg_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  nscg_cmd_t    cmd,
    output nscg_status_t status,
    input  logic [11:0]  frame_width,
    input  logic [11:0]  frame_height,
    input  logic [11:0]  guide_x_left,
    input  logic [11:0]  guide_x_right,
    input  logic [11:0]  guide_y_top,
    input  logic [11:0]  guide_y_bottom,
    input  logic [1:0]   horz_mode,
    input  logic [1:0]   vert_mode,
    input  logic [11:0]  box_width,
    input  logic [11:0]  box_height,
    input  logic [15:0]  tex_left,
    input  logic [15:0]  tex_top,
    input  logic [15:0]  tex_right,
    input  logic [15:0]  tex_bottom,
    output logic [15:0]  src_x,
    output logic [15:0]  src_y,
    output logic [15:0]  src_w,
    output logic [15:0]  src_h,
    output logic [13:0]  dst_x,
    output logic [13:0]  dst_y,
    output logic [13:0]  dst_w,
    output logic [13:0]  dst_h,
    output logic         last_cell
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // Points stay in 16-bit two's complement; the dst outputs keep 14 bits.
    typedef logic signed [15:0] pt_t;

    logic [11:0] bw_reg, bh_reg, fw_reg, fh_reg;
    logic [15:0] tl_reg, tt_reg, tr_reg, tb_reg;
    logic [15:0] gx1_reg, gx2_reg, gy1_reg, gy2_reg;
    pt_t         px_reg [MAX_POINTS];
    pt_t         py_reg [MAX_POINTS];
    logic [CW-1:0] nx_reg, ny_reg;
    pt_t         curx_reg, cury_reg;
    logic        xdone_reg, ydone_reg;
    logic [IW-1:0] xc_reg, yc_reg;

    logic [15:0] div_lo, div_hi, div_res;
    logic [11:0] div_g, div_f;
    logic        div_done;
    logic [11:0] gr, gb;

    assign gr = (guide_x_right == 12'd0) ? fw_reg : guide_x_right;
    assign gb = (guide_y_bottom == 12'd0) ? fh_reg : guide_y_bottom;

    always_comb
    begin
        case (cmd.div_sel)
            2'd0:    begin div_lo = tl_reg; div_hi = tr_reg; div_g = guide_x_left; div_f = fw_reg; end
            2'd1:    begin div_lo = tl_reg; div_hi = tr_reg; div_g = gr; div_f = fw_reg; end
            2'd2:    begin div_lo = tt_reg; div_hi = tb_reg; div_g = guide_y_top; div_f = fh_reg; end
            default: begin div_lo = tt_reg; div_hi = tb_reg; div_g = gb; div_f = fh_reg; end
        endcase
    end

    nscg_divider u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .lo     (div_lo),
        .hi     (div_hi),
        .guide  (div_g),
        .frame  (div_f),
        .done   (div_done),
        .result (div_res)
    );

    logic [1:0] dsel_reg;

    // One step of the point builder for one axis.
    typedef struct packed {
        logic   done;
        logic   write;
        pt_t    val;
        pt_t    cur;
        logic [CW-1:0] n;
    } step_t;

    function automatic step_t axis_step(input logic [1:0] mode, input pt_t box,
                                        input pt_t frame, input pt_t ng, input pt_t fg,
                                        input pt_t cur, input logic [CW-1:0] n);
        step_t s;
        pt_t   edge_len, bound, centre, nxt;
        logic  tile, full;
        int    closing;
        edge_len = frame - fg;
        bound = box - edge_len;
        centre = fg - ng;
        tile = (mode == MODE_TILE) || (mode == MODE_TILE_FULL);
        full = (mode == MODE_TILE_FULL);
        closing = full ? 2 : 1;
        nxt = cur + centre;
        s.done = 1'b0;
        s.write = 1'b1;
        s.cur = cur;
        s.n = n + CW'(1);
        s.val = '0;
        if (n == CW'(0))
            s.val = '0;
        else if (n == CW'(1))
        begin
            s.val = ng;
            s.cur = ng;
        end
        else if (!tile)
        begin
            s.val = (n == CW'(2)) ? bound : box;
            s.done = (n == CW'(3));
        end
        if (tile && n >= CW'(2))
        begin
            // cur tracks the last centre point; a pending squeezed pair is
            // signalled by the marker in cur.
            if (cur == 16'sh7FFF)
            begin
                s.val = box;
                s.done = 1'b1;
            end
            else if (nxt <= bound && (int'(n) + 1 + closing) <= MAX_POINTS)
            begin
                s.val = nxt;
                s.cur = nxt;
            end
            else if (full)
            begin
                s.val = bound;
                s.cur = 16'sh7FFF;
            end
            else
            begin
                s.val = cur + edge_len;
                s.done = 1'b1;
            end
        end
        return s;
    endfunction

    step_t sx, sy;
    always_comb
    begin
        sx = axis_step(horz_mode, pt_t'(bw_reg), pt_t'(fw_reg), pt_t'(guide_x_left),
                       pt_t'(gr), curx_reg, nx_reg);
        sy = axis_step(vert_mode, pt_t'(bh_reg), pt_t'(fh_reg), pt_t'(guide_y_top),
                       pt_t'(gb), cury_reg, ny_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            xdone_reg <= 1'b0;
            ydone_reg <= 1'b0;
            xc_reg <= '0;
            yc_reg <= '0;
            last_cell <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                nx_reg <= '0;
                ny_reg <= '0;
                xdone_reg <= 1'b0;
                ydone_reg <= 1'b0;
                xc_reg <= '0;
                yc_reg <= '0;
            end
            else if (cmd.pts_step)
            begin
                if (!xdone_reg)
                begin
                    nx_reg <= sx.n;
                    xdone_reg <= sx.done;
                end
                if (!ydone_reg)
                begin
                    ny_reg <= sy.n;
                    ydone_reg <= sy.done;
                end
            end
            else if (cmd.advance)
            begin
                if (32'(xc_reg) + 2 == 32'(nx_reg))
                begin
                    xc_reg <= '0;
                    yc_reg <= yc_reg + IW'(1);
                end
                else
                    xc_reg <= xc_reg + IW'(1);
            end
            if (cmd.emit)
                last_cell <= status.last;
        end
    end

    logic [1:0] xi, yi;
    logic [15:0] gxa, gxb, gya, gyb;
    always_comb
    begin
        xi = (xc_reg == '0) ? 2'd0 : (32'(xc_reg) + 2 == 32'(nx_reg)) ? 2'd2 : 2'd1;
        yi = (yc_reg == '0) ? 2'd0 : (32'(yc_reg) + 2 == 32'(ny_reg)) ? 2'd2 : 2'd1;
        case (xi)
            2'd0:    begin gxa = tl_reg;  gxb = gx1_reg; end
            2'd1:    begin gxa = gx1_reg; gxb = gx2_reg; end
            default: begin gxa = gx2_reg; gxb = tr_reg;  end
        endcase
        case (yi)
            2'd0:    begin gya = tt_reg;  gyb = gy1_reg; end
            2'd1:    begin gya = gy1_reg; gyb = gy2_reg; end
            default: begin gya = gy2_reg; gyb = tb_reg;  end
        endcase
    end

    pt_t pxa, pxb, pya, pyb;
    assign pxa = px_reg[xc_reg];
    assign pxb = px_reg[IW'(32'(xc_reg) + 1)];
    assign pya = py_reg[yc_reg];
    assign pyb = py_reg[IW'(32'(yc_reg) + 1)];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bw_reg <= box_width;
            bh_reg <= box_height;
            fw_reg <= (frame_width == 12'd0) ? 12'd1 : frame_width;
            fh_reg <= (frame_height == 12'd0) ? 12'd1 : frame_height;
            tl_reg <= tex_left;
            tt_reg <= tex_top;
            tr_reg <= tex_right;
            tb_reg <= tex_bottom;
            curx_reg <= '0;
            cury_reg <= '0;
        end
        if (cmd.div_start)
            dsel_reg <= cmd.div_sel;
        if (div_done)
        begin
            case (dsel_reg)
                2'd0:    gx1_reg <= div_res;
                2'd1:    gx2_reg <= div_res;
                2'd2:    gy1_reg <= div_res;
                default: gy2_reg <= div_res;
            endcase
        end
        if (cmd.pts_step)
        begin
            if (!xdone_reg)
            begin
                px_reg[nx_reg[IW-1:0]] <= sx.val;
                curx_reg <= sx.cur;
            end
            if (!ydone_reg)
            begin
                py_reg[ny_reg[IW-1:0]] <= sy.val;
                cury_reg <= sy.cur;
            end
        end
        if (cmd.emit)
        begin
            src_x <= gxa;
            src_y <= gya;
            src_w <= gxb - gxa;
            src_h <= gyb - gya;
            dst_x <= pxa[13:0];
            dst_y <= pya[13:0];
            dst_w <= 14'(pxb - pxa);
            dst_h <= 14'(pyb - pya);
        end
    end

    assign status.div_done = div_done;
    assign status.pts_done = xdone_reg && ydone_reg;
    assign status.last = (32'(xc_reg) + 2 == 32'(nx_reg)) && (32'(yc_reg) + 2 == 32'(ny_reg));

endmodule

FILE: design/nscg_controller.sv
// ----------------------------------------------------------------------------
// Nine-slice controller
// Sequences capture, four guide divisions, point building and cell output.
// ----------------------------------------------------------------------------
module nscg_controller
    import nscg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  nscg_status_t status,
    output nscg_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_PTS  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       last_reg, last_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    sel_next   = 2'd0;
                    state_next = ST_DIV;
                end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
                if (status.div_done)
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = (sel_reg == 2'd3) ? ST_PTS : ST_DIV;
                end
            ST_PTS:
            begin
                cmd.pts_step = 1'b1;
                if (status.pts_done)
                begin
                    cmd.pts_step = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                last_next  = status.last;
                state_next = ST_OUT;
            end
            ST_OUT:
                if (out_ready)
                begin
                    if (last_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_EMIT;
                    end
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            last_reg  <= last_next;
        end
    end

endmodule

FILE: design/nine_slice_cell_generator.sv
// ----------------------------------------------------------------------------
// Nine-slice cell generator
// Splits a target box into nine-slice cells and streams their rectangles.
// ----------------------------------------------------------------------------
// The user must set the block up through the configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) only while it is idle; this is not enforced.
// Each input transfer carries one box size and the frame's texture rectangle.
// The block then runs four texture guide divisions on a shared bit-serial
// divider, builds both axis point lists one point per cycle, and streams
// one output transfer per cell, row by row, with last_cell set on the
// final cell of the box.
// A new box is accepted only after the last cell of the previous box has
// been transferred. When the receiver stalls, the current cell is held on
// the output registers and the block simply waits.
// Reset clears the handshake state and sets the frame size registers to 1
// and all other configuration registers to 0.
// ----------------------------------------------------------------------------
module nine_slice_cell_generator
    import nscg_pkg::*;
#(
    parameter int MAX_POINTS_PER_AXIS = DEFAULT_MAX_POINTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] box_width,
    input  logic [11:0] box_height,
    input  logic [15:0] tex_left,
    input  logic [15:0] tex_top,
    input  logic [15:0] tex_right,
    input  logic [15:0] tex_bottom,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] src_x,
    output logic [15:0] src_y,
    output logic [15:0] src_w,
    output logic [15:0] src_h,
    output logic signed [13:0] dst_x,
    output logic signed [13:0] dst_y,
    output logic signed [13:0] dst_w,
    output logic signed [13:0] dst_h,
    output logic        last_cell
);

    logic [11:0] frame_width_reg, frame_height_reg;
    logic [11:0] guide_x_left_reg, guide_x_right_reg;
    logic [11:0] guide_y_top_reg, guide_y_bottom_reg;
    logic [1:0]  horz_mode_reg, vert_mode_reg;

    nscg_cmd_t    cmd;
    nscg_status_t status;

    assign cfg_ready = 1'b1;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= 12'd1;
            frame_height_reg   <= 12'd1;
            guide_x_left_reg   <= '0;
            guide_x_right_reg  <= '0;
            guide_y_top_reg    <= '0;
            guide_y_bottom_reg <= '0;
            horz_mode_reg      <= MODE_STRETCH;
            vert_mode_reg      <= MODE_STRETCH;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_W:  frame_width_reg    <= cfg_data;
                REG_FRAME_H:  frame_height_reg   <= cfg_data;
                REG_GUIDE_XL: guide_x_left_reg   <= cfg_data;
                REG_GUIDE_XR: guide_x_right_reg  <= cfg_data;
                REG_GUIDE_YT: guide_y_top_reg    <= cfg_data;
                REG_GUIDE_YB: guide_y_bottom_reg <= cfg_data;
                REG_HMODE:    horz_mode_reg      <= cfg_data[1:0];
                REG_VMODE:    vert_mode_reg      <= cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    nscg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    nscg_datapath #(
        .MAX_POINTS (MAX_POINTS_PER_AXIS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .frame_width    (frame_width_reg),
        .frame_height   (frame_height_reg),
        .guide_x_left   (guide_x_left_reg),
        .guide_x_right  (guide_x_right_reg),
        .guide_y_top    (guide_y_top_reg),
        .guide_y_bottom (guide_y_bottom_reg),
        .horz_mode      (horz_mode_reg),
        .vert_mode      (vert_mode_reg),
        .box_width      (box_width),
        .box_height     (box_height),
        .tex_left       (tex_left),
        .tex_top        (tex_top),
        .tex_right      (tex_right),
        .tex_bottom     (tex_bottom),
        .src_x          (src_x),
        .src_y          (src_y),
        .src_w          (src_w),
        .src_h          (src_h),
        .dst_x          (dst_x),
        .dst_y          (dst_y),
        .dst_w          (dst_w),
        .dst_h          (dst_h),
        .last_cell      (last_cell)
    );

endmodule
